// ===== sv/lpmd_pkg.sv =====
package lpmd_pkg;

    // default widths of the header length fields
    localparam int LENGTH_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;

    // message framing
    localparam int HDR_BYTES     = 6;
    localparam int HDR_LEN_BYTES = 4;
    localparam int MIN_TOTAL     = 2;

    // part counter saturates one past the largest index
    localparam int INDEX_W   = 16;
    localparam int PARTS_W   = INDEX_W + 1;
    localparam logic [PARTS_W-1:0] PARTS_SAT = PARTS_W'(1) << INDEX_W;

    // one result of the parser
    typedef struct packed {
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic [INDEX_W-1:0] part_index;
        logic               part_end;
        logic               message_end;
        logic               message_error;
    } result_t;

    // zero-based index of the current part from the number of parts seen
    function automatic logic [INDEX_W-1:0] part_index_of(input logic [PARTS_W-1:0] found);
        logic [PARTS_W-1:0] dec;
        dec = found - PARTS_W'(1);
        return (found == '0) ? '0 : dec[INDEX_W-1:0];
    endfunction

endpackage

// ===== sv/lpmd_parse.sv =====
module lpmd_parse #(
    parameter int LENGTH_BITS = lpmd_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = lpmd_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    output logic              res_valid,
    output lpmd_pkg::result_t res
);
    import lpmd_pkg::*;

    localparam int HBC_W = $clog2(HDR_BYTES);
    localparam int LBC_W = $clog2(HDR_LEN_BYTES);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HBC_W-1:0]       hbc_reg, hbc_next;
    logic [LBC_W-1:0]       lbc_reg, lbc_next;
    logic [LENGTH_BITS-1:0] body_reg, body_next;
    logic [LENGTH_BITS-1:0] part_reg, part_next;
    logic [COUNT_BITS-1:0]  exp_reg, exp_next;
    logic [PARTS_W-1:0]     pf_reg, pf_next;

    logic [LENGTH_BITS+7:0] body_wide, part_wide;
    logic [COUNT_BITS+7:0]  exp_wide;
    logic [LENGTH_BITS-1:0] body_shift, part_shift, body_dec, part_dec, body_sub;
    logic [COUNT_BITS-1:0]  exp_shift;
    logic [PARTS_W-1:0]     pf_inc;
    logic                   finish;

    // shifted and decremented field values
    assign body_wide  = {body_reg, data_byte};
    assign part_wide  = {part_reg, data_byte};
    assign exp_wide   = {exp_reg, data_byte};
    assign body_shift = body_wide[LENGTH_BITS-1:0];
    assign part_shift = part_wide[LENGTH_BITS-1:0];
    assign exp_shift  = exp_wide[COUNT_BITS-1:0];
    assign body_dec   = body_reg - LENGTH_BITS'(1);
    assign part_dec   = part_reg - LENGTH_BITS'(1);
    assign body_sub   = body_reg - LENGTH_BITS'(MIN_TOTAL);
    assign pf_inc     = (pf_reg == PARTS_SAT) ? pf_reg : pf_reg + PARTS_W'(1);

    // per-byte parse step
    always_comb
    begin
        phase_next = phase_reg;
        hbc_next   = hbc_reg;
        lbc_next   = lbc_reg;
        body_next  = body_reg;
        part_next  = part_reg;
        exp_next   = exp_reg;
        pf_next    = pf_reg;
        res_valid  = 1'b0;
        res        = '0;
        finish     = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    body_next = body_dec;
                    part_next = part_shift;
                    if (lbc_reg == LBC_W'(HDR_LEN_BYTES - 1))
                    begin
                        lbc_next = '0;
                        pf_next  = pf_inc;
                        if (part_shift == '0)
                        begin
                            // empty part closes at once
                            res_valid      = 1'b1;
                            res.part_end   = 1'b1;
                            res.part_index = part_index_of(pf_inc);
                            if (body_dec == '0)
                            begin
                                res.message_end   = 1'b1;
                                res.message_error = (pf_inc != PARTS_W'(exp_reg));
                                finish            = 1'b1;
                            end
                        end
                        else if (body_dec == '0)
                        begin
                            res_valid         = 1'b1;
                            res.message_end   = 1'b1;
                            res.message_error = 1'b1;
                            finish            = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        lbc_next = lbc_reg + LBC_W'(1);
                        // body ends inside a length field
                        if (body_dec == '0)
                        begin
                            res_valid         = 1'b1;
                            res.message_end   = 1'b1;
                            res.message_error = 1'b1;
                            finish            = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid         = 1'b1;
                    res.payload_valid = 1'b1;
                    res.payload_byte  = data_byte;
                    res.part_index    = part_index_of(pf_reg);
                    body_next         = body_dec;
                    part_next         = part_dec;
                    if (body_dec == '0)
                    begin
                        // truncated part is an error, part is not closed
                        res.part_end      = (part_dec == '0);
                        res.message_end   = 1'b1;
                        res.message_error = (part_dec != '0) || (pf_reg != PARTS_W'(exp_reg));
                        finish            = 1'b1;
                    end
                    else if (part_dec == '0)
                    begin
                        res.part_end = 1'b1;
                        phase_next   = PH_LENGTH;
                    end
                end
                default:
                begin
                    // header bytes, also any stray phase code
                    phase_next = PH_HEADER;
                    if (hbc_reg < HBC_W'(HDR_LEN_BYTES))
                        body_next = body_shift;
                    else
                        exp_next = exp_shift;
                    hbc_next = hbc_reg + HBC_W'(1);
                    if (hbc_reg == HBC_W'(HDR_BYTES - 1))
                    begin
                        hbc_next = '0;
                        if (body_reg < LENGTH_BITS'(MIN_TOTAL))
                        begin
                            res_valid         = 1'b1;
                            res.message_end   = 1'b1;
                            res.message_error = 1'b1;
                            finish            = 1'b1;
                        end
                        else if (body_sub == '0)
                        begin
                            res_valid         = 1'b1;
                            res.message_end   = 1'b1;
                            res.message_error = (exp_shift != '0);
                            finish            = 1'b1;
                        end
                        else
                        begin
                            body_next  = body_sub;
                            phase_next = PH_LENGTH;
                            lbc_next   = '0;
                            part_next  = '0;
                        end
                    end
                end
            endcase
            // message done: back to a clean header state
            if (finish)
            begin
                phase_next = PH_HEADER;
                hbc_next   = '0;
                lbc_next   = '0;
                body_next  = '0;
                part_next  = '0;
                exp_next   = '0;
                pf_next    = '0;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hbc_reg   <= '0;
            lbc_reg   <= '0;
            body_reg  <= '0;
            part_reg  <= '0;
            exp_reg   <= '0;
            pf_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hbc_reg   <= hbc_next;
            lbc_reg   <= lbc_next;
            body_reg  <= body_next;
            part_reg  <= part_next;
            exp_reg   <= exp_next;
            pf_reg    <= pf_next;
        end
    end

    // checks
    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.payload_valid) |-> (phase_reg == PH_PAYLOAD))
        else $error("payload byte outside payload phase");

    a_error_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.message_error) |-> res.message_end)
        else $error("error flag without message end");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.message_end) |=> (phase_reg == PH_HEADER && pf_reg == '0))
        else $error("state not cleared after message end");

    a_payload_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (part_reg != '0 && body_reg != '0))
        else $error("payload phase with exhausted counter");

    a_length_body: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LENGTH) |-> (body_reg != '0))
        else $error("length phase with empty body");

endmodule

// ===== sv/lpmd_out_reg.sv =====
module lpmd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lpmd_pkg::result_t res,
    input  logic              m_axis_tready,
    output logic              m_axis_tvalid,
    output logic [23:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    output logic [2:0]        m_axis_tuser
);
    import lpmd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // hold a result until the downstream transfer
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {res_reg.part_index, res_reg.payload_byte};
    assign m_axis_tlast  = res_reg.message_end;
    assign m_axis_tuser  = {res_reg.message_error, res_reg.part_end, res_reg.payload_valid};

endmodule

// ===== sv/length_prefixed_message_deframer_unit.sv =====
// Length-prefixed message deframer. Takes one stream byte per transfer and returns at most
// one result per byte: payload bytes tagged with their part index, part end marks (empty
// parts included) and a message end mark with an error verdict on tlast/tuser. Header and
// part length bytes give no result except where a part or the message closes. A byte is
// accepted every cycle while the result side keeps up. It passes an input register, one
// parser step and the result register on its way to the output. A result held by a stalled
// output holds the parser and the input register, and the input then waits. The rate is set
// by the parser state update, which finishes one byte per cycle while it is not held.
module length_prefixed_message_deframer_unit #(
    parameter int LENGTH_BITS = lpmd_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = lpmd_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] part_index
    output logic        m_axis_tlast,   // message_end
    output logic [2:0]  m_axis_tuser    // [0] payload_valid, [1] part_end, [2] message_error
);
    import lpmd_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // the parser steps when the result register can take a result
    assign advance       = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    lpmd_parse #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpmd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && res_valid),
        .res           (res),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
